@@ rtl/core/sine_table_generator_defines.svh @@
// ============================================================================
// Sine table generator assertion macros
// Assertion helpers shared by the sine table generator RTL; they expand to
// nothing when SYNTHESIS is defined.
// ============================================================================
`ifndef SINE_TABLE_GENERATOR_DEFINES_SVH
`define SINE_TABLE_GENERATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define STG_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sine_table_generator: property failed");
`define STG_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("sine_table_generator: forbidden condition seen");
`else
`define STG_ASSERT(label, prop)
`define STG_ASSERT_NEVER(label, expr)
`endif
`endif

@@ rtl/core/stg_pkg.sv @@
// ============================================================================
// Sine table generator package
// Request and response types, controller interface structs and constants.
// ============================================================================
package stg_pkg;

    typedef struct packed {
        logic        cmd;
        logic [12:0] freq_distance_mm;
        logic [12:0] amp_distance_mm;
        logic [9:0]  read_index;
    } stg_req_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic [9:0]         entry_count;
        logic [8:0]         amplitude_mm;
        logic [9:0]         period_length;
    } stg_rsp_t;

    localparam logic CMD_GEN  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [9:0] FREQ_LO     = 10'd40;
    localparam logic [9:0] FREQ_HI     = 10'd400;
    localparam logic [8:0] AMP_LO      = 9'd100;
    localparam logic [8:0] AMP_HI      = 9'd400;
    localparam logic [9:0] PERIOD_RST  = 10'd1000;
    localparam logic [8:0] AMP_RST     = 9'd500;

    localparam int CORDIC_W     = 20;
    localparam int CORDIC_STEPS = 16;
    localparam int DIV_Q_BITS   = 17;
    localparam int DIVIDEND_W   = 42;
    localparam int DIVISOR_W    = 25;

    // The gain divisor 32768000 is 2^18 * 125; the division by 125 is done by
    // multiplying with ceil(2^29 / 125), which is exact for 22-bit operands.
    localparam int SCALE_SHIFT = 18;
    localparam int SCALE_W     = 22;
    localparam int RECIP_SHIFT = 29;
    localparam logic [22:0] RECIP_125 = 23'd4294968;

    localparam logic [32:0] HALF_PI_Q32      = 33'd6746518852;
    localparam logic [16:0] THETA_MAX        = 17'd102943;
    localparam logic signed [CORDIC_W-1:0] CORDIC_INV_GAIN = 20'sd39797;

    typedef struct packed {
        logic accept_gen;
        logic accept_read;
        logic angle_mul;
        logic div_start;
        logic div_sel_scale;
        logic rot_load;
        logic rot_step;
        logic scale_mul;
        logic write_sample;
        logic load_rsp;
        logic rsp_is_read;
    } stg_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic div_done;
        logic rot_last;
        logic last_k;
    } stg_status_t;

    function automatic logic signed [CORDIC_W-1:0] atan_q16(input logic [3:0] idx);
        logic signed [CORDIC_W-1:0] val;
        case (idx)
            4'd0:    val = 20'sd51472;
            4'd1:    val = 20'sd30386;
            4'd2:    val = 20'sd16055;
            4'd3:    val = 20'sd8150;
            4'd4:    val = 20'sd4091;
            4'd5:    val = 20'sd2047;
            4'd6:    val = 20'sd1024;
            4'd7:    val = 20'sd512;
            4'd8:    val = 20'sd256;
            4'd9:    val = 20'sd128;
            4'd10:   val = 20'sd64;
            4'd11:   val = 20'sd32;
            4'd12:   val = 20'sd16;
            4'd13:   val = 20'sd8;
            4'd14:   val = 20'sd4;
            4'd15:   val = 20'sd2;
            default: val = 20'sd0;
        endcase
        return val;
    endfunction

endpackage

@@ rtl/core/stg_div.sv @@
// ============================================================================
// Sine table generator divider
// Restoring divider producing one quotient bit per cycle; the quotient is
// known to fit in DIV_Q_BITS bits.
// ============================================================================
module stg_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [stg_pkg::DIVIDEND_W-1:0]  dividend,
    input  logic [stg_pkg::DIVISOR_W-1:0]   divisor,
    output logic [stg_pkg::DIV_Q_BITS-1:0]  quotient,
    output logic                            done
);
    import stg_pkg::*;

    localparam int DSR_W = DIVISOR_W + DIV_Q_BITS - 1;

    logic [DIVIDEND_W-1:0] rem_reg, rem_next;
    logic [DSR_W-1:0]      dsr_reg, dsr_next;
    logic [DIV_Q_BITS-1:0] quo_reg, quo_next;
    logic [4:0]            cnt_reg, cnt_next;
    logic                  fits;

    assign fits = DIVIDEND_W'(dsr_reg) <= rem_reg;

    always_comb
    begin
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            rem_next = dividend;
            dsr_next = {divisor, {(DIV_Q_BITS-1){1'b0}}};
            quo_next = '0;
            cnt_next = 5'(DIV_Q_BITS);
        end
        else if (cnt_reg != 5'd0)
        begin
            if (fits)
            begin
                rem_next = rem_reg - DIVIDEND_W'(dsr_reg);
            end
            quo_next = {quo_reg[DIV_Q_BITS-2:0], fits};
            dsr_next = dsr_reg >> 1;
            cnt_next = cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 5'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign done     = (cnt_reg == 5'd0);

endmodule

@@ rtl/core/stg_ctrl.sv @@
`include "sine_table_generator_defines.svh"
// ============================================================================
// Sine table generator controller
// Waits out the clearing pass, then sequences table regeneration, table reads and the response hand-off.
// ============================================================================
module stg_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic                req_cmd,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    input  stg_pkg::stg_status_t status,
    output stg_pkg::stg_cmd_t    cmd
);
    import stg_pkg::*;

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_ANGLE   = 4'd2;
    localparam logic [3:0] S_DIVA_GO = 4'd3;
    localparam logic [3:0] S_DIVA    = 4'd4;
    localparam logic [3:0] S_ROT     = 4'd5;
    localparam logic [3:0] S_MUL     = 4'd6;
    localparam logic [3:0] S_DIVS_GO = 4'd7;
    localparam logic [3:0] S_DIVS    = 4'd8;
    localparam logic [3:0] S_WRITE   = 4'd9;
    localparam logic [3:0] S_RESP    = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       is_read_reg, is_read_next;
    logic       rsp_valid_reg, rsp_valid_next;
    logic       accept;
    logic       slot_free;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign slot_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next     = state_reg;
        is_read_next   = is_read_reg;
        rsp_valid_next = rsp_valid_reg;
        cmd            = '0;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            S_CLEAR:
            begin
                if (status.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    is_read_next = (req_cmd == CMD_READ);
                    if (req_cmd == CMD_READ)
                    begin
                        cmd.accept_read = 1'b1;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        cmd.accept_gen = 1'b1;
                        state_next     = S_ANGLE;
                    end
                end
            end
            S_ANGLE:
            begin
                cmd.angle_mul = 1'b1;
                state_next    = S_DIVA_GO;
            end
            S_DIVA_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVA;
            end
            S_DIVA:
            begin
                if (status.div_done)
                begin
                    cmd.rot_load = 1'b1;
                    state_next   = S_ROT;
                end
            end
            S_ROT:
            begin
                cmd.rot_step = 1'b1;
                if (status.rot_last)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.scale_mul = 1'b1;
                state_next    = S_DIVS_GO;
            end
            S_DIVS_GO:
            begin
                cmd.div_sel_scale = 1'b1;
                state_next        = S_DIVS;
            end
            S_DIVS:
            begin
                // The reciprocal product is registered during this cycle.
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.write_sample = 1'b1;
                state_next = status.last_k ? S_RESP : S_ANGLE;
            end
            S_RESP:
            begin
                if (slot_free)
                begin
                    cmd.load_rsp   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        cmd.rsp_is_read = is_read_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            is_read_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            is_read_reg   <= is_read_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

    // The divider must have finished its previous job before it is restarted.
    `STG_ASSERT(a_div_idle_on_start, cmd.div_start |-> status.div_done)
    `STG_ASSERT(a_rsp_from_resp, $rose(rsp_valid_reg) |-> $past(state_reg == S_RESP))

endmodule

@@ rtl/core/stg_datapath.sv @@
`include "sine_table_generator_defines.svh"
// ============================================================================
// Sine table generator datapath
// Holds the sample store, the settings registers, the phase tracking, the
// CORDIC rotator, the scaling path and the response register.
// ============================================================================
module stg_datapath #(
    parameter int MAX_PERIOD = 512
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  stg_pkg::stg_req_t     req,
    input  stg_pkg::stg_cmd_t     cmd,
    output stg_pkg::stg_status_t  status,
    output stg_pkg::stg_rsp_t     rsp
);
    import stg_pkg::*;

    localparam int AW   = $clog2(MAX_PERIOD);
    localparam int RP_W = SCALE_W + 23;

    // Settings registers.
    logic [9:0] period_reg, period_next;
    logic [8:0] amp_reg, amp_next;
    logic [9:0] count_reg, count_next;
    logic [9:0] freq_clamped;
    logic [8:0] amp_clamped;

    // Phase tracking: k, and 4k split into quadrant and remainder.
    logic [8:0] k_reg, k_next;
    logic [8:0] r_reg, r_next;
    logic [1:0] q_reg, q_next;
    logic [8:0] r_step;

    // Clearing pass.
    logic [AW-1:0] clr_idx_reg, clr_idx_next;
    logic          clr_done_reg, clr_done_next;

    // Shared product register feeding the divider and the scaling path.
    logic [DIVIDEND_W-1:0] prod_reg;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic [DIV_Q_BITS-1:0] div_quo;
    logic                  div_done;

    // Scaling by 32767 / 32768000.
    logic [DIVIDEND_W-1:0] scl_full;
    logic [SCALE_W-1:0]    scl_reg;
    logic [RP_W-1:0]       recip_prod;
    logic [16:0]           scl_quo_reg;

    // CORDIC.
    logic signed [CORDIC_W-1:0] x_reg, y_reg, z_reg;
    logic signed [CORDIC_W-1:0] dx, dy, sel_s;
    logic [3:0]                 iter_reg;
    logic [17:0]                mag;
    logic                       neg_reg;

    // Saturated sample.
    logic [15:0] sample_val;

    // Memory.
    logic signed [15:0] mem [MAX_PERIOD];
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic signed [15:0] mem_wdata;
    logic [12:0]        rd_idx;
    logic signed [15:0] rd_data_reg;
    logic               rd_ok_reg;

    always_comb
    begin
        freq_clamped = (req.freq_distance_mm < 13'(FREQ_LO)) ? FREQ_LO :
                       (req.freq_distance_mm > 13'(FREQ_HI)) ? FREQ_HI :
                       req.freq_distance_mm[9:0];
        amp_clamped  = (req.amp_distance_mm < 13'(AMP_LO)) ? AMP_LO :
                       (req.amp_distance_mm > 13'(AMP_HI)) ? AMP_HI :
                       req.amp_distance_mm[8:0];
    end

    always_comb
    begin
        period_next = period_reg;
        amp_next    = amp_reg;
        count_next  = count_reg;
        if (cmd.accept_gen)
        begin
            period_next = freq_clamped;
            amp_next    = amp_clamped;
            count_next  = {freq_clamped[8:0], 1'b0};
        end
    end

    // Advancing k by one moves 4k on by four, which never passes N twice.
    assign r_step = r_reg + 9'd4;

    always_comb
    begin
        k_next = k_reg;
        r_next = r_reg;
        q_next = q_reg;
        if (cmd.accept_gen)
        begin
            k_next = '0;
            r_next = '0;
            q_next = '0;
        end
        else if (cmd.write_sample)
        begin
            k_next = k_reg + 9'd1;
            if (10'(r_step) >= period_reg)
            begin
                r_next = 9'(10'(r_step) - period_reg);
                q_next = q_reg + 2'd1;
            end
            else
            begin
                r_next = r_step;
            end
        end
    end

    always_comb
    begin
        clr_idx_next  = clr_idx_reg;
        clr_done_next = clr_done_reg;
        if (!clr_done_reg)
        begin
            if (clr_idx_reg == AW'(MAX_PERIOD - 1))
            begin
                clr_done_next = 1'b1;
            end
            else
            begin
                clr_idx_next = clr_idx_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg   <= PERIOD_RST;
            amp_reg      <= AMP_RST;
            count_reg    <= '0;
            clr_idx_reg  <= '0;
            clr_done_reg <= 1'b0;
        end
        else
        begin
            period_reg   <= period_next;
            amp_reg      <= amp_next;
            count_reg    <= count_next;
            clr_idx_reg  <= clr_idx_next;
            clr_done_reg <= clr_done_next;
        end
    end

    // CORDIC step and quadrant mapping.
    assign dx = y_reg >>> iter_reg;
    assign dy = x_reg >>> iter_reg;

    always_comb
    begin
        case (q_reg)
            2'd0:    sel_s = y_reg;
            2'd1:    sel_s = x_reg;
            2'd2:    sel_s = -y_reg;
            2'd3:    sel_s = -x_reg;
            default: sel_s = y_reg;
        endcase
        mag = sel_s[CORDIC_W-1] ? 18'(-sel_s) : 18'(sel_s);
    end

    assign div_dividend = prod_reg;
    assign div_divisor  = DIVISOR_W'({period_reg, 16'b0});

    // Product times 32767, then the power-of-two part of the divisor.
    assign scl_full   = (prod_reg << 15) - prod_reg;
    assign recip_prod = RP_W'(scl_reg) * RP_W'(RECIP_125);

    always_ff @(posedge clk)
    begin
        if (cmd.accept_gen || cmd.write_sample)
        begin
            k_reg <= k_next;
            r_reg <= r_next;
            q_reg <= q_next;
        end
        if (cmd.angle_mul)
        begin
            prod_reg <= DIVIDEND_W'(r_reg) * DIVIDEND_W'(HALF_PI_Q32);
        end
        else if (cmd.scale_mul)
        begin
            prod_reg <= DIVIDEND_W'(mag) * DIVIDEND_W'(amp_reg);
            neg_reg  <= sel_s[CORDIC_W-1];
        end
        if (cmd.div_sel_scale)
        begin
            scl_reg <= scl_full[SCALE_SHIFT+SCALE_W-1:SCALE_SHIFT];
        end
        scl_quo_reg <= 17'(recip_prod >> RECIP_SHIFT);
        if (cmd.rot_load)
        begin
            x_reg    <= CORDIC_INV_GAIN;
            y_reg    <= '0;
            z_reg    <= CORDIC_W'(div_quo);
            iter_reg <= '0;
        end
        else if (cmd.rot_step)
        begin
            if (!z_reg[CORDIC_W-1])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan_q16(iter_reg);
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan_q16(iter_reg);
            end
            iter_reg <= iter_reg + 4'd1;
        end
    end

    stg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .done     (div_done)
    );

    always_comb
    begin
        if (neg_reg)
        begin
            sample_val = (scl_quo_reg > 17'd32768) ? 16'h8000 : 16'(-scl_quo_reg);
        end
        else
        begin
            sample_val = (scl_quo_reg > 17'd32767) ? 16'h7fff : scl_quo_reg[15:0];
        end
    end

    assign mem_we    = !clr_done_reg || cmd.write_sample;
    assign mem_waddr = clr_done_reg ? AW'(k_reg) : clr_idx_reg;
    assign mem_wdata = clr_done_reg ? $signed(sample_val) : 16'sd0;
    assign rd_idx    = 13'(req.read_index[9:1]);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.accept_read)
        begin
            rd_data_reg <= mem[rd_idx[AW-1:0]];
            rd_ok_reg   <= rd_idx < 13'(MAX_PERIOD);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_rsp)
        begin
            rsp.sample        <= (cmd.rsp_is_read && rd_ok_reg) ? rd_data_reg : 16'sd0;
            rsp.entry_count   <= count_reg;
            rsp.amplitude_mm  <= amp_reg;
            rsp.period_length <= period_reg;
        end
    end

    assign status.clear_done = clr_done_reg;
    assign status.div_done   = div_done;
    assign status.rot_last   = (iter_reg == 4'(CORDIC_STEPS - 1));
    assign status.last_k     = (10'(k_reg) == period_reg - 10'd1);

    `STG_ASSERT(a_k_in_period, cmd.write_sample |-> (10'(k_reg) < period_reg))
    `STG_ASSERT(a_theta_in_quadrant, cmd.rot_load |-> (div_quo <= THETA_MAX))

endmodule

@@ rtl/core/sine_table_generator.sv @@
// ============================================================================
// Sine table generator
// Builds a scaled sine table on a generate request and serves table reads.
// ============================================================================
//   channel | direction | payload   | handshake
//   req     | in        | stg_req_t | req_valid / req_ready
//   rsp     | out       | stg_rsp_t | rsp_valid / rsp_ready
//
// A read request passes through a registered memory read and then the
// response load. A generate request runs per sample through a phase
// division, 16 CORDIC rotations and six further steps, N samples in all.
// After reset a clearing pass writes zero to all MAX_PERIOD entries, one per
// cycle; req_ready stays low meanwhile. One request is worked on at a time;
// a stalled response holds in its register while the next request is taken.
module sine_table_generator #(
    parameter int MAX_PERIOD = 512
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  stg_pkg::stg_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output stg_pkg::stg_rsp_t rsp
);
    import stg_pkg::*;

    stg_cmd_t    cmd;
    stg_status_t status;

    stg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_cmd   (req.cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .cmd       (cmd)
    );

    stg_datapath #(
        .MAX_PERIOD (MAX_PERIOD)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cmd    (cmd),
        .status (status),
        .rsp    (rsp)
    );

endmodule
